@@ design/signed_binary_to_decimal_ascii_core_macros.svh @@
// assertion macros shared by the signed binary to decimal ascii core
`ifndef SIGNED_BINARY_TO_DECIMAL_ASCII_CORE_MACROS_SVH
`define SIGNED_BINARY_TO_DECIMAL_ASCII_CORE_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define SB2DA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("sb2da assertion failed");
// boolean condition must never be seen outside reset
`define SB2DA_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("sb2da forbidden condition seen");
`else
`define SB2DA_ASSERT(lbl, clk, rst_n, prop)
`define SB2DA_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

@@ design/sb2da_pkg.sv @@
// shared constants, types and state encodings for the decimal ascii core
`timescale 1ns / 1ps

package sb2da_pkg;

    // port width of the value field and the width actually converted
    localparam int IN_W        = 64;
    localparam int VALUE_WIDTH = 64;

    // enough decimal digits for any VALUE_WIDTH-bit magnitude
    localparam int NUM_DIGITS = (VALUE_WIDTH * 3) / 10 + 1;
    localparam int BCD_W      = NUM_DIGITS * 4;
    localparam int CNT_W      = $clog2(VALUE_WIDTH + 1);
    localparam int LEFT_W     = $clog2(NUM_DIGITS + 1);

    localparam int CHAR_W = 7;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 7'd57;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_IDX_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // classified item: sign and unsigned magnitude
    typedef struct packed {
        logic                   neg;
        logic [VALUE_WIDTH-1:0] mag;
    } t_job;

    // converted item: sign and packed bcd digits, most significant on top
    typedef struct packed {
        logic             neg;
        logic [BCD_W-1:0] bcd;
    } t_digits;

    typedef enum logic [1:0] {
        CONV_IDLE,
        CONV_SHIFT,
        CONV_DONE
    } t_conv_state;

    typedef enum logic [1:0] {
        EMIT_IDLE,
        EMIT_SKIP,
        EMIT_SIGN,
        EMIT_DIGITS
    } t_emit_state;

endpackage

@@ design/signed_binary_to_decimal_ascii_core.sv @@
// top level: signed integer to decimal ascii text, one character per result
//
// input side is a queue: present i_value with push; the item is taken at a
// clock edge with push high and full low. output side is a queue too: while
// empty is low the oldest character sits on o_text_char, o_last_char marks
// the final character of a number, and it is taken at an edge with pop high.
// a negative number starts with '-', zero gives the single character '0'.
// throughput is set by the bit-serial bcd converter, which takes the next
// number only once the emitter has accepted the last; characters leave at
// one per cycle while the receiver pops, and that overlaps the conversion
// of the next number.
// a two-entry queue sits between the front end and the converter, so new
// numbers are taken while earlier ones convert or wait. when the receiver
// stalls, the character register holds, the emitter and then the converter
// wait, the queue fills and full rises. nothing is lost.
// synchronous reset empties the queue and returns all control to idle.
`timescale 1ns / 1ps
`include "signed_binary_to_decimal_ascii_core_macros.svh"

module signed_binary_to_decimal_ascii_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [sb2da_pkg::IN_W-1:0]    i_value,
    output logic                          empty,
    input  logic                          pop,
    output logic [sb2da_pkg::CHAR_W-1:0]  o_text_char,
    output logic                          o_last_char
);

    // front end to queue
    logic               w_fifo_wr;
    logic               w_fifo_full;
    sb2da_pkg::t_job    w_front_job;

    // queue to converter
    logic               w_fifo_empty;
    logic               w_fifo_rd;
    sb2da_pkg::t_job    w_fifo_job;

    // converter to emitter
    logic               w_conv_valid;
    logic               w_emit_ready;
    sb2da_pkg::t_digits w_conv_digits;

    logic               w_out_valid;

    // sign and magnitude split of the incoming item
    sb2da_front u_front (
        .i_push      (push),
        .i_value     (i_value),
        .o_full      (full),
        .i_fifo_full (w_fifo_full),
        .o_wr        (w_fifo_wr),
        .o_job       (w_front_job)
    );

    // decouples intake from the long conversion
    sb2da_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_fifo_wr),
        .i_data  (w_front_job),
        .o_full  (w_fifo_full),
        .i_rd    (w_fifo_rd),
        .o_empty (w_fifo_empty),
        .o_data  (w_fifo_job)
    );

    // one magnitude bit per cycle into packed bcd
    sb2da_conv u_conv (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (~w_fifo_empty),
        .i_job       (w_fifo_job),
        .o_job_take  (w_fifo_rd),
        .o_valid     (w_conv_valid),
        .i_ready     (w_emit_ready),
        .o_digits    (w_conv_digits)
    );

    // leading zero drop, sign, digits, with a registered output character
    sb2da_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_conv_valid),
        .i_digits    (w_conv_digits),
        .o_ready     (w_emit_ready),
        .o_out_valid (w_out_valid),
        .i_out_pop   (pop),
        .o_char      (o_text_char),
        .o_last      (o_last_char)
    );

    assign empty = ~w_out_valid;

    // a minus sign is always followed by at least one digit
    `SB2DA_ASSERT(a_top_minus_not_last, i_clk, i_rst_n, (!empty && (o_text_char == sb2da_pkg::CHAR_MINUS)) |-> !o_last_char)

endmodule

@@ design/sb2da_front.sv @@
// front end: takes the input item, splits it into sign and magnitude
`timescale 1ns / 1ps

module sb2da_front (
    input  logic                        i_push,
    input  logic [sb2da_pkg::IN_W-1:0]  i_value,
    output logic                        o_full,
    input  logic                        i_fifo_full,
    output logic                        o_wr,
    output sb2da_pkg::t_job             o_job
);

    logic [sb2da_pkg::VALUE_WIDTH-1:0] w_v;
    logic                              w_neg;

    assign w_v   = i_value[sb2da_pkg::VALUE_WIDTH-1:0];
    assign w_neg = w_v[sb2da_pkg::VALUE_WIDTH-1];

    // two's complement negation keeps the most negative value as 2^(w-1)
    assign o_job.neg = w_neg;
    assign o_job.mag = w_neg ? (~w_v + 1'b1) : w_v;

    assign o_full = i_fifo_full;
    assign o_wr   = i_push & ~i_fifo_full;

endmodule

@@ design/sb2da_fifo.sv @@
// short queue of classified items between front end and converter
`timescale 1ns / 1ps
`include "signed_binary_to_decimal_ascii_core_macros.svh"

module sb2da_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  sb2da_pkg::t_job i_data,
    output logic            o_full,
    input  logic            i_rd,
    output logic            o_empty,
    output sb2da_pkg::t_job o_data
);

    sb2da_pkg::t_job                    r_mem [sb2da_pkg::FIFO_DEPTH];
    logic [sb2da_pkg::FIFO_IDX_W-1:0]   r_wr_ptr;
    logic [sb2da_pkg::FIFO_IDX_W-1:0]   r_rd_ptr;
    logic [sb2da_pkg::FIFO_CNT_W-1:0]   r_count;
    logic                               w_wr;
    logic                               w_rd;

    assign o_full  = (r_count == sb2da_pkg::FIFO_CNT_W'(sb2da_pkg::FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign w_wr    = i_wr & ~o_full;
    assign w_rd    = i_rd & ~o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    function automatic logic [sb2da_pkg::FIFO_IDX_W-1:0] f_inc(
        input logic [sb2da_pkg::FIFO_IDX_W-1:0] ptr
    );
        if (ptr == sb2da_pkg::FIFO_IDX_W'(sb2da_pkg::FIFO_DEPTH - 1)) begin
            return '0;
        end
        return ptr + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= f_inc(r_wr_ptr);
            end
            if (w_rd) begin
                r_rd_ptr <= f_inc(r_rd_ptr);
            end
            case ({w_wr, w_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `SB2DA_ASSERT(a_fifo_cnt_range, i_clk, i_rst_n, r_count <= sb2da_pkg::FIFO_CNT_W'(sb2da_pkg::FIFO_DEPTH))
    `SB2DA_ASSERT(a_fifo_cnt_up, i_clk, i_rst_n, (w_wr && !w_rd) |=> (r_count == $past(r_count) + 1'b1))

endmodule

@@ design/sb2da_conv.sv @@
// back end converter: shift-and-add-3 binary to bcd, one bit per cycle
`timescale 1ns / 1ps
`include "signed_binary_to_decimal_ascii_core_macros.svh"

module sb2da_conv (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_valid,
    input  sb2da_pkg::t_job    i_job,
    output logic               o_job_take,
    output logic               o_valid,
    input  logic               i_ready,
    output sb2da_pkg::t_digits o_digits
);

    sb2da_pkg::t_conv_state              r_state;
    sb2da_pkg::t_conv_state              n_state;
    logic [sb2da_pkg::VALUE_WIDTH-1:0]   r_shift;
    logic [sb2da_pkg::VALUE_WIDTH-1:0]   n_shift;
    logic [sb2da_pkg::BCD_W-1:0]         r_bcd;
    logic [sb2da_pkg::BCD_W-1:0]         n_bcd;
    logic                                r_neg;
    logic                                n_neg;
    logic [sb2da_pkg::CNT_W-1:0]         r_cnt;
    logic [sb2da_pkg::CNT_W-1:0]         n_cnt;
    logic [sb2da_pkg::BCD_W-1:0]         w_adj;
    logic                                w_load;
    logic                                w_shift_en;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sb2da_pkg::CONV_IDLE: begin
                if (i_job_valid) begin
                    n_state = sb2da_pkg::CONV_SHIFT;
                end
            end
            sb2da_pkg::CONV_SHIFT: begin
                if (r_cnt == sb2da_pkg::CNT_W'(1)) begin
                    n_state = sb2da_pkg::CONV_DONE;
                end
            end
            sb2da_pkg::CONV_DONE: begin
                if (i_ready) begin
                    n_state = i_job_valid ? sb2da_pkg::CONV_SHIFT : sb2da_pkg::CONV_IDLE;
                end
            end
            default: n_state = sb2da_pkg::CONV_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_valid    = 1'b0;
        w_load     = 1'b0;
        w_shift_en = 1'b0;
        case (r_state)
            sb2da_pkg::CONV_IDLE:  w_load = i_job_valid;
            sb2da_pkg::CONV_SHIFT: w_shift_en = 1'b1;
            sb2da_pkg::CONV_DONE: begin
                o_valid = 1'b1;
                w_load  = i_ready & i_job_valid;
            end
            default: begin
                o_valid    = 1'b0;
                w_load     = 1'b0;
                w_shift_en = 1'b0;
            end
        endcase
    end

    assign o_job_take = w_load;

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int d = 0; d < sb2da_pkg::NUM_DIGITS; d++) begin
            w_adj[d*4 +: 4] = (r_bcd[d*4 +: 4] >= 4'd5) ? r_bcd[d*4 +: 4] + 4'd3
                                                        : r_bcd[d*4 +: 4];
        end
    end

    always_comb begin
        n_shift = r_shift;
        n_bcd   = r_bcd;
        n_neg   = r_neg;
        n_cnt   = r_cnt;
        if (w_load) begin
            n_shift = i_job.mag;
            n_bcd   = '0;
            n_neg   = i_job.neg;
            n_cnt   = sb2da_pkg::CNT_W'(sb2da_pkg::VALUE_WIDTH);
        end else if (w_shift_en) begin
            n_bcd   = {w_adj[sb2da_pkg::BCD_W-2:0], r_shift[sb2da_pkg::VALUE_WIDTH-1]};
            n_shift = {r_shift[sb2da_pkg::VALUE_WIDTH-2:0], 1'b0};
            n_cnt   = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sb2da_pkg::CONV_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
        r_bcd   <= n_bcd;
        r_neg   <= n_neg;
    end

    assign o_digits.neg = r_neg;
    assign o_digits.bcd = r_bcd;

    `SB2DA_ASSERT(a_conv_all_bits, i_clk, i_rst_n, (r_state == sb2da_pkg::CONV_DONE) |-> (r_cnt == '0))
    `SB2DA_ASSERT(a_conv_take_loads, i_clk, i_rst_n, o_job_take |=> (r_state == sb2da_pkg::CONV_SHIFT))

endmodule

@@ design/sb2da_emit.sv @@
// back end emitter: drops leading zeros, sends sign and digit characters
`timescale 1ns / 1ps
`include "signed_binary_to_decimal_ascii_core_macros.svh"

module sb2da_emit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  sb2da_pkg::t_digits            i_digits,
    output logic                          o_ready,
    output logic                          o_out_valid,
    input  logic                          i_out_pop,
    output logic [sb2da_pkg::CHAR_W-1:0]  o_char,
    output logic                          o_last
);

    sb2da_pkg::t_emit_state               r_state;
    sb2da_pkg::t_emit_state               n_state;
    logic [sb2da_pkg::BCD_W-1:0]          r_bcd;
    logic                                 r_neg;
    logic [sb2da_pkg::LEFT_W-1:0]         r_left;
    logic                                 r_out_valid;
    logic [sb2da_pkg::CHAR_W-1:0]         r_out_char;
    logic                                 r_out_last;
    logic [3:0]                           w_top;
    logic                                 w_out_free;
    logic                                 w_final;
    logic                                 w_load;
    logic                                 w_shift;
    logic                                 w_put;
    logic [sb2da_pkg::CHAR_W-1:0]         w_put_char;
    logic                                 w_put_last;

    assign w_top      = r_bcd[sb2da_pkg::BCD_W-1 -: 4];
    assign w_out_free = ~r_out_valid | i_out_pop;
    assign w_final    = (r_left == sb2da_pkg::LEFT_W'(1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sb2da_pkg::EMIT_IDLE: begin
                if (i_valid) begin
                    n_state = sb2da_pkg::EMIT_SKIP;
                end
            end
            sb2da_pkg::EMIT_SKIP: begin
                if ((w_top != 4'd0) || w_final) begin
                    n_state = r_neg ? sb2da_pkg::EMIT_SIGN : sb2da_pkg::EMIT_DIGITS;
                end
            end
            sb2da_pkg::EMIT_SIGN: begin
                if (w_out_free) begin
                    n_state = sb2da_pkg::EMIT_DIGITS;
                end
            end
            sb2da_pkg::EMIT_DIGITS: begin
                if (w_out_free && w_final) begin
                    n_state = sb2da_pkg::EMIT_IDLE;
                end
            end
            default: n_state = sb2da_pkg::EMIT_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_ready    = 1'b0;
        w_load     = 1'b0;
        w_shift    = 1'b0;
        w_put      = 1'b0;
        w_put_char = sb2da_pkg::CHAR_ZERO + {3'b000, w_top};
        w_put_last = 1'b0;
        case (r_state)
            sb2da_pkg::EMIT_IDLE: begin
                o_ready = 1'b1;
                w_load  = i_valid;
            end
            sb2da_pkg::EMIT_SKIP: begin
                w_shift = (w_top == 4'd0) && !w_final;
            end
            sb2da_pkg::EMIT_SIGN: begin
                w_put      = w_out_free;
                w_put_char = sb2da_pkg::CHAR_MINUS;
            end
            sb2da_pkg::EMIT_DIGITS: begin
                w_put      = w_out_free;
                w_shift    = w_out_free;
                w_put_last = w_final;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sb2da_pkg::EMIT_IDLE;
            r_out_valid <= 1'b0;
            r_left      <= '0;
        end else begin
            r_state <= n_state;
            if (w_put) begin
                r_out_valid <= 1'b1;
            end else if (i_out_pop) begin
                r_out_valid <= 1'b0;
            end
            if (w_load) begin
                r_left <= sb2da_pkg::LEFT_W'(sb2da_pkg::NUM_DIGITS);
            end else if (w_shift) begin
                r_left <= r_left - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_bcd <= i_digits.bcd;
            r_neg <= i_digits.neg;
        end else if (w_shift) begin
            r_bcd <= {r_bcd[sb2da_pkg::BCD_W-5:0], 4'd0};
        end
        if (w_put) begin
            r_out_char <= w_put_char;
            r_out_last <= w_put_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_char      = r_out_char;
    assign o_last      = r_out_last;

    `SB2DA_ASSERT(a_emit_char_legal, i_clk, i_rst_n, r_out_valid |-> ((r_out_char == sb2da_pkg::CHAR_MINUS) || ((r_out_char >= sb2da_pkg::CHAR_ZERO) && (r_out_char <= sb2da_pkg::CHAR_NINE))))

endmodule
